// ===== rtl/lidar_point_angle_ring_splitter_top_assert.svh =====
// Assertion macros shared by the lidar angle and ring splitter RTL.
`ifndef LIDAR_POINT_ANGLE_RING_SPLITTER_TOP_ASSERT_SVH
`define LIDAR_POINT_ANGLE_RING_SPLITTER_TOP_ASSERT_SVH
`ifndef SYNTH
`define LPARS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpars assertion failed");
`define LPARS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpars assertion failed");
`else
`define LPARS_ASSERT_SAME(label, clk, rst, ante, cons)
`define LPARS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/lpars_pkg.sv =====
// Shared types, constants and the arctangent table of the lidar angle splitter.
package lpars_pkg;

   localparam int ACC_Q            = 16;
   localparam int ACC_W            = 26;
   localparam int GUARD_BITS       = 20;
   localparam int TAB_IDX_W        = 5;
   localparam int VERT_W           = 16;
   localparam int HORIZ_W          = 17;
   localparam int TRUNC_W          = 9;
   localparam int RING_W           = 10;
   localparam int JUMP_W           = 17;
   localparam int HOLD_W           = 8;
   localparam int CSR_IDX_W        = 1;
   localparam int DEG_HALF_TURN    = 180;
   localparam int DEG_QUARTER_TURN = 90;

   localparam logic [RING_W-1:0] RING_MAX      = 10'd1023;
   localparam logic [JUMP_W-1:0] JUMP_RESET    = 17'd23040;
   localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 8'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_JUMP_THRESHOLD = 1'b0,
      REG_HOLDOFF_POINTS = 1'b1
   } csr_reg_type;

   // round(atan(2^-i) * 180 / pi * 2^16)
   function automatic logic [ACC_W-1:0] atan_tab_entry(input logic [TAB_IDX_W-1:0] idx);
      logic [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 26'd2949120;
         5'd1:    val = 26'd1740967;
         5'd2:    val = 26'd919879;
         5'd3:    val = 26'd466945;
         5'd4:    val = 26'd234379;
         5'd5:    val = 26'd117304;
         5'd6:    val = 26'd58666;
         5'd7:    val = 26'd29335;
         5'd8:    val = 26'd14668;
         5'd9:    val = 26'd7334;
         5'd10:   val = 26'd3667;
         5'd11:   val = 26'd1833;
         5'd12:   val = 26'd917;
         5'd13:   val = 26'd458;
         5'd14:   val = 26'd229;
         5'd15:   val = 26'd115;
         5'd16:   val = 26'd57;
         5'd17:   val = 26'd29;
         5'd18:   val = 26'd14;
         5'd19:   val = 26'd7;
         5'd20:   val = 26'd4;
         5'd21:   val = 26'd2;
         5'd22:   val = 26'd1;
         default: val = 26'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/lidar_point_angle_ring_splitter_top.sv =====
// Top level of the lidar point angle and scan ring splitter.
//
// The block takes one lidar point (x, y, z in millimeters, plus a scan start
// flag) per input transaction on the req_ channel and returns one result
// transaction on the rsp_ channel: the elevation and azimuth angles in
// 1/2^ANGLE_FRAC_BITS degree, whether the point was jump-tested, whether it
// opens a new scan ring, its index in the scan and the saturating ring count.
// An item occupies the block through the bit-serial square root of x*x + y*y,
// one root bit per cycle, followed by the elevation pass of the shared CORDIC
// unit, one rotation per cycle; the azimuth pass of the same unit overlaps the
// root. req_stall is high while an item is in flight.
// The result sits in an output register; a stalled result holds its payload,
// and the next point is accepted while it waits. A further result is only
// loaded once the pending one has been taken.
// Reset is synchronous and active high; it resets the control, configuration
// and per-scan registers; the first point after reset is treated as a scan start.
// The csr_ channel writes the jump threshold and holdoff length; it is always
// ready and should only be used while the block is idle.
`include "lidar_point_angle_ring_splitter_top_assert.svh"
module lidar_point_angle_ring_splitter_top
   import lpars_pkg::*;
#(
   parameter int COORD_BITS      = 18,
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STEPS    = 16,
   parameter int INDEX_BITS      = 18
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_x,
   input  logic signed [COORD_BITS-1:0]  req_y,
   input  logic signed [COORD_BITS-1:0]  req_z,
   input  logic                          req_scan_start,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VERT_W-1:0]      rsp_vert_angle,
   output logic signed [HORIZ_W-1:0]     rsp_horiz_angle,
   output logic                          rsp_tested,
   output logic                          rsp_ring_start,
   output logic [INDEX_BITS-1:0]         rsp_point_index,
   output logic [RING_W-1:0]             rsp_ring_count,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [JUMP_W-1:0]             csr_wdata
);

   localparam int IW    = COORD_BITS + 2;
   localparam int HW    = ANGLE_FRAC_BITS + 10;
   localparam int DW    = ANGLE_FRAC_BITS + 20;
   localparam int SHIFT = ACC_Q - ANGLE_FRAC_BITS;
   localparam logic [ACC_W-1:0] HALF = ACC_W'((64'd1 << SHIFT) >> 1);
   localparam logic signed [ACC_W-1:0] LIM_H = ACC_W'(DEG_HALF_TURN << ACC_Q);
   localparam logic signed [ACC_W-1:0] LIM_V = ACC_W'(DEG_QUARTER_TURN << ACC_Q);
   localparam logic signed [HW-1:0] UNIT_M1 = HW'((64'd1 << ANGLE_FRAC_BITS) - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SQX    = 7'b0000010,
      ST_SQY    = 7'b0000100,
      ST_ROOT   = 7'b0001000,
      ST_WAIT_H = 7'b0010000,
      ST_VERT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   // Clamp a Q16 degree angle and round it to the output grid, half away from zero.
   function automatic logic signed [HW-1:0] to_output(input logic signed [ACC_W-1:0] acc,
                                                     input logic signed [ACC_W-1:0] lim);
      logic signed [ACC_W-1:0] clamped;
      logic [ACC_W-1:0]        mag;
      logic [ACC_W-1:0]        rnd;
      clamped = acc;
      if (acc > lim) begin
         clamped = lim;
      end
      if (acc < -lim) begin
         clamped = -lim;
      end
      mag = (clamped < 0) ? $unsigned(-clamped) : $unsigned(clamped);
      rnd = (mag + HALF) >> SHIFT;
      return (clamped < 0) ? -$signed(HW'(rnd)) : $signed(HW'(rnd));
   endfunction

   state_type state_ff, state_in;

   // Latched point and arithmetic registers.
   logic signed [COORD_BITS-1:0]  x_ff;
   logic signed [COORD_BITS-1:0]  y_ff;
   logic signed [COORD_BITS-1:0]  z_ff;
   logic                          scan_ff;
   logic [2*COORD_BITS-1:0]       mul_ff;
   logic [2*COORD_BITS-1:0]       xsq_ff;
   logic signed [HW-1:0]          horiz_ff;

   // Configuration and per-scan state.
   logic [JUMP_W-1:0]             jump_ff;
   logic [HOLD_W-1:0]             holdoff_ff;
   logic signed [TRUNC_W-1:0]     last_ff,  last_in;
   logic signed [TRUNC_W-1:0]     blast_ff, blast_in;
   logic                          ha_ff,    ha_in;
   logic [HOLD_W-1:0]             hc_ff,    hc_in;
   logic [INDEX_BITS-1:0]         pc_ff,    pc_in;
   logic [RING_W-1:0]             rc_ff,    rc_in;

   // Result register.
   logic                          rsp_valid_ff;
   logic signed [VERT_W-1:0]      rsp_vert_ff;
   logic signed [HORIZ_W-1:0]     rsp_horiz_ff;
   logic                          rsp_tested_ff;
   logic                          rsp_ring_ff;
   logic [INDEX_BITS-1:0]         rsp_index_ff;
   logic [RING_W-1:0]             rsp_count_ff;

   logic                          accept;
   logic                          out_free;
   logic                          commit;
   logic signed [COORD_BITS-1:0]  sq_op;
   logic signed [2*COORD_BITS-1:0] sq_ext;
   logic                          cordic_start;
   logic signed [IW-1:0]          cordic_x;
   logic signed [IW-1:0]          cordic_y;
   logic                          cordic_busy;
   logic signed [ACC_W-1:0]       cordic_acc;
   logic                          root_start;
   logic                          root_busy;
   logic [COORD_BITS-1:0]         radius;
   logic                          both_done;

   logic                          first;
   logic signed [HW-1:0]          vert_val;
   logic signed [HW-1:0]          horiz_adj;
   logic signed [HW-1:0]          trunc_full;
   logic signed [TRUNC_W-1:0]     trunc_deg;
   logic signed [TRUNC_W-1:0]     last_sel;
   logic signed [TRUNC_W-1:0]     blast_sel;
   logic                          ha_sel;
   logic [HOLD_W-1:0]             hc_sel;
   logic [INDEX_BITS-1:0]         pc_sel;
   logic [RING_W-1:0]             rc_sel;
   logic                          holding;
   logic                          tested;
   logic                          ring;
   logic signed [DW-1:0]          hz_ext;
   logic signed [DW-1:0]          diff_last;
   logic signed [DW-1:0]          diff_blast;
   logic signed [DW-1:0]          thr_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign both_done = !cordic_busy && !root_busy;
   assign commit    = (state_ff == ST_FINISH) && out_free;
   assign csr_ready = 1'b1;

   // The one multiplier forms x*x and then y*y.
   assign sq_op  = (state_ff == ST_SQX) ? x_ff : y_ff;
   assign sq_ext = (2*COORD_BITS)'(sq_op);

   // The CORDIC unit runs the azimuth atan2(y, -x) first, then the elevation
   // atan2(z, radius) once the square root has finished.
   always_comb begin
      cordic_start = 1'b0;
      cordic_x     = -IW'(x_ff);
      cordic_y     = IW'(y_ff);
      if (state_ff == ST_SQX) begin
         cordic_start = 1'b1;
      end else if (state_ff == ST_WAIT_H) begin
         cordic_x     = $signed(IW'(radius));
         cordic_y     = IW'(z_ff);
         cordic_start = both_done;
      end
   end

   assign root_start = (state_ff == ST_ROOT);

   lpars_isqrt #(
      .COORD_BITS (COORD_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (xsq_ff + mul_ff),
      .busy     (root_busy),
      .root     (radius)
   );

   lpars_cordic #(
      .COORD_BITS   (COORD_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .xin   (cordic_x),
      .yin   (cordic_y),
      .busy  (cordic_busy),
      .angle (cordic_acc)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SQX;
            end
         end
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_ROOT;
         ST_ROOT:   state_in = ST_WAIT_H;
         ST_WAIT_H: begin
            if (both_done) begin
               state_in = ST_VERT;
            end
         end
         ST_VERT: begin
            if (!cordic_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Ring test. A scan start, or a point counter still at zero, restarts all
   // per-scan state with this point's own truncated azimuth before the test.
   always_comb begin
      vert_val   = to_output(cordic_acc, LIM_V);
      horiz_adj  = horiz_ff[HW-1] ? (horiz_ff + UNIT_M1) : horiz_ff;
      trunc_full = horiz_adj >>> ANGLE_FRAC_BITS;
      trunc_deg  = trunc_full[TRUNC_W-1:0];

      first     = scan_ff || (pc_ff == '0);
      pc_sel    = first ? '0 : pc_ff;
      rc_sel    = first ? '0 : rc_ff;
      ha_sel    = first ? 1'b1 : ha_ff;
      hc_sel    = first ? '0 : hc_ff;
      last_sel  = first ? trunc_deg : last_ff;
      blast_sel = first ? trunc_deg : blast_ff;

      holding = ha_sel && (hc_sel < holdoff_ff);
      tested  = !holding;

      hz_ext     = DW'(horiz_ff);
      thr_ext    = $signed(DW'(jump_ff));
      diff_last  = hz_ext - (DW'(last_sel) <<< ANGLE_FRAC_BITS);
      diff_blast = hz_ext - (DW'(blast_sel) <<< ANGLE_FRAC_BITS);
      ring       = tested && (diff_last > thr_ext) && (diff_blast > thr_ext);

      ha_in    = holding || ring;
      hc_in    = holding ? (hc_sel + 1'b1) : '0;
      rc_in    = (ring && (rc_sel < RING_MAX)) ? (rc_sel + 1'b1) : rc_sel;
      pc_in    = (pc_sel != '1) ? (pc_sel + 1'b1) : pc_sel;
      blast_in = last_sel;
      last_in  = trunc_deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         jump_ff      <= JUMP_RESET;
         holdoff_ff   <= HOLDOFF_RESET;
         last_ff      <= '0;
         blast_ff     <= '0;
         ha_ff        <= 1'b1;
         hc_ff        <= '0;
         pc_ff        <= '0;
         rc_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            last_ff      <= last_in;
            blast_ff     <= blast_in;
            ha_ff        <= ha_in;
            hc_ff        <= hc_in;
            pc_ff        <= pc_in;
            rc_ff        <= rc_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_JUMP_THRESHOLD: jump_ff    <= csr_wdata;
               REG_HOLDOFF_POINTS: holdoff_ff <= csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_x;
         y_ff    <= req_y;
         z_ff    <= req_z;
         scan_ff <= req_scan_start;
      end
      if (state_ff == ST_SQX || state_ff == ST_SQY) begin
         mul_ff <= $unsigned(sq_ext * sq_ext);
      end
      if (state_ff == ST_SQY) begin
         xsq_ff <= mul_ff;
      end
      if (state_ff == ST_WAIT_H && both_done) begin
         horiz_ff <= to_output(cordic_acc, LIM_H);
      end
      if (commit) begin
         rsp_vert_ff   <= VERT_W'(vert_val);
         rsp_horiz_ff  <= HORIZ_W'(horiz_ff);
         rsp_tested_ff <= tested;
         rsp_ring_ff   <= ring;
         rsp_index_ff  <= pc_sel;
         rsp_count_ff  <= rc_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vert_angle  = rsp_vert_ff;
   assign rsp_horiz_angle = rsp_horiz_ff;
   assign rsp_tested      = rsp_tested_ff;
   assign rsp_ring_start  = rsp_ring_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_ring_count  = rsp_count_ff;

   `LPARS_ASSERT_SAME(a_ring_tested, clock, reset, rsp_valid_ff && rsp_ring_ff, rsp_tested_ff)
   `LPARS_ASSERT_NEXT(a_vert_launch, clock, reset, state_ff == ST_WAIT_H && both_done, state_ff == ST_VERT && cordic_busy)
   `LPARS_ASSERT_NEXT(a_result_load, clock, reset, commit, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// ===== rtl/lpars_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module lpars_isqrt
   import lpars_pkg::*;
#(
   parameter int COORD_BITS = 18
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2*COORD_BITS-1:0]   radicand,
   output logic                      busy,
   output logic [COORD_BITS-1:0]     root
);

   localparam int RW    = COORD_BITS + 2;
   localparam int CNT_W = $clog2(COORD_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_BITS - 1);

   logic                      busy_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [2*COORD_BITS-1:0]   rad_ff;
   logic [RW-1:0]             rem_ff;
   logic [COORD_BITS-1:0]     root_ff;
   logic [RW-1:0]             rem_try;
   logic [RW-1:0]             trial;
   logic                      fits;

   always_comb begin
      rem_try = {rem_ff[RW-3:0], rad_ff[2*COORD_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      fits    = (rem_try >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[2*COORD_BITS-3:0], 2'b00};
         rem_ff  <= fits ? (rem_try - trial) : rem_try;
         root_ff <= {root_ff[COORD_BITS-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/lpars_cordic.sv =====
// Shared vectoring CORDIC unit that iterates one rotation per cycle.
`include "lidar_point_angle_ring_splitter_top_assert.svh"
module lpars_cordic
   import lpars_pkg::*;
#(
   parameter int COORD_BITS   = 18,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COORD_BITS+1:0]  xin,
   input  logic signed [COORD_BITS+1:0]  yin,
   output logic                          busy,
   output logic signed [ACC_W-1:0]       angle
);

   localparam int IW = COORD_BITS + 2;
   localparam int CW = COORD_BITS + GUARD_BITS + 5;
   localparam int SW = $clog2(CORDIC_STEPS);
   localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);
   localparam logic signed [ACC_W-1:0] QUARTER = ACC_W'(DEG_QUARTER_TURN << ACC_Q);

   logic                     busy_ff;
   logic [SW-1:0]            step_ff;
   logic                     zero_ff;
   logic signed [CW-1:0]     x_ff;
   logic signed [CW-1:0]     y_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic signed [IW-1:0]     x0;
   logic signed [IW-1:0]     y0;
   logic signed [ACC_W-1:0]  a0;
   logic signed [CW-1:0]     dx;
   logic signed [CW-1:0]     dy;
   logic signed [ACC_W-1:0]  step_angle;
   logic signed [CW-1:0]     x_in;
   logic signed [CW-1:0]     y_in;
   logic signed [ACC_W-1:0]  acc_in;
   logic [TAB_IDX_W-1:0]     tab_idx;

   // Left half-plane vectors are turned by a quarter turn first.
   always_comb begin
      x0 = xin;
      y0 = yin;
      a0 = '0;
      if (xin < 0) begin
         if (yin >= 0) begin
            x0 = yin;
            y0 = -xin;
            a0 = QUARTER;
         end else begin
            x0 = -yin;
            y0 = xin;
            a0 = -QUARTER;
         end
      end
   end

   always_comb begin
      tab_idx    = TAB_IDX_W'(step_ff);
      step_angle = $signed(atan_tab_entry(tab_idx));
      dx         = x_ff >>> step_ff;
      dy         = y_ff >>> step_ff;
      if (y_ff >= 0) begin
         x_in   = x_ff + dy;
         y_in   = y_ff - dx;
         acc_in = acc_ff + step_angle;
      end else begin
         x_in   = x_ff - dy;
         y_in   = y_ff + dx;
         acc_in = acc_ff - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         zero_ff <= (xin == '0) && (yin == '0);
         x_ff    <= CW'(x0) <<< GUARD_BITS;
         y_ff    <= CW'(y0) <<< GUARD_BITS;
         acc_ff  <= a0;
      end else if (busy_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
      end
   end

   assign busy  = busy_ff;
   assign angle = zero_ff ? '0 : acc_ff;

   `LPARS_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff)
   `LPARS_ASSERT_NEXT(a_step_end, clock, reset, busy_ff && !start && step_ff == STEP_LAST, !busy_ff)

endmodule
